FILE: rtl/utc_date_time_advance_assert.svh
// ---------------------------------------------------------------------------
// utc_date_time_advance assertion macros
// Concurrent assertion shorthands on aclk, with and without reset masking.
// ---------------------------------------------------------------------------
`ifndef UTC_DATE_TIME_ADVANCE_ASSERT_SVH
`define UTC_DATE_TIME_ADVANCE_ASSERT_SVH

// checked only while out of reset
`define UTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define UTC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/utc_pkg.sv
// ---------------------------------------------------------------------------
// utc_pkg
// Calendar time type, field limits and month length helpers.
// ---------------------------------------------------------------------------
package utc_pkg;

    typedef struct packed {
        logic [9:0] millisecond;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } cal_time_t;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic [10:0] MS_PER_SEC      = 11'd1000;
    localparam logic [10:0] MS_TWO_SEC      = 11'd2000;
    localparam logic [6:0]  SEC_PER_MIN     = 7'd60;
    localparam logic [6:0]  MIN_PER_HOUR    = 7'd60;
    localparam logic [5:0]  HOUR_PER_DAY    = 6'd24;
    localparam logic [4:0]  MONTH_PER_YEAR  = 5'd12;
    localparam logic [7:0]  YEAR_WRAP       = 8'd100;
    localparam logic [6:0]  YEAR_CENTURY    = 7'd100;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [5:0] LEN_LONG  = 6'd31;
    localparam logic [5:0] LEN_SHORT = 6'd30;
    localparam logic [5:0] LEN_LEAP  = 6'd29;
    localparam logic [5:0] LEN_FEB   = 6'd28;

    // Year counts from 2000: divisible by four except 2100 (2000 itself is leap)
    function automatic logic is_leap(input logic [6:0] year);
        is_leap = (year[1:0] == 2'b00) && (year != YEAR_CENTURY);
    endfunction

    function automatic logic [5:0] month_len(input logic [3:0] month,
                                             input logic [6:0] year);
        case (month)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC: month_len = LEN_LONG;
            MON_FEB:                   month_len = is_leap(year) ? LEN_LEAP : LEN_FEB;
            default:                   month_len = LEN_SHORT;
        endcase
    endfunction

endpackage

FILE: rtl/utc_step.sv
// ---------------------------------------------------------------------------
// utc_step
// Next calendar time for one item: load, add elapsed ms with carry, or hold.
// ---------------------------------------------------------------------------
module utc_step (
    input  utc_pkg::cal_time_t cur,
    input  utc_pkg::cal_time_t load,
    input  logic               action,
    input  logic               pps_seen,
    input  logic [9:0]         elapsed_ms,
    output utc_pkg::cal_time_t nxt,
    output logic               applied
);

    logic [10:0] ms_sum;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [5:0]  len;
    logic [4:0]  mon_inc;
    logic [7:0]  year_inc;
    logic        c_ms, c_sec, c_min, c_hour, c_day, c_mon;
    utc_pkg::cal_time_t adv;

    always_comb begin
        ms_sum   = {1'b0, cur.millisecond} + {1'b0, elapsed_ms};
        sec_inc  = {1'b0, cur.second} + 7'd1;
        min_inc  = {1'b0, cur.minute} + 7'd1;
        hour_inc = {1'b0, cur.hour} + 6'd1;
        day_inc  = {1'b0, cur.day} + 6'd1;
        mon_inc  = {1'b0, cur.month} + 5'd1;
        year_inc = {1'b0, cur.year} + 8'd1;
        len      = utc_pkg::month_len(cur.month, cur.year);

        c_ms   = ms_sum >= utc_pkg::MS_PER_SEC;
        c_sec  = c_ms   && (sec_inc >= utc_pkg::SEC_PER_MIN);
        c_min  = c_sec  && (min_inc >= utc_pkg::MIN_PER_HOUR);
        c_hour = c_min  && (hour_inc >= utc_pkg::HOUR_PER_DAY);
        c_day  = c_hour && (day_inc > len);
        c_mon  = c_day  && (mon_inc > utc_pkg::MONTH_PER_YEAR);

        adv = cur;
        if (!c_ms) begin
            adv.millisecond = ms_sum[9:0];
        end else if (ms_sum >= utc_pkg::MS_TWO_SEC) begin
            adv.millisecond = 10'(ms_sum - utc_pkg::MS_TWO_SEC);
        end else begin
            adv.millisecond = 10'(ms_sum - utc_pkg::MS_PER_SEC);
        end
        if (c_ms) begin
            adv.second = c_sec ? 6'(sec_inc - utc_pkg::SEC_PER_MIN) : sec_inc[5:0];
        end
        if (c_sec) begin
            adv.minute = c_min ? 6'(min_inc - utc_pkg::MIN_PER_HOUR) : min_inc[5:0];
        end
        if (c_min) begin
            adv.hour = c_hour ? 5'(hour_inc - utc_pkg::HOUR_PER_DAY) : hour_inc[4:0];
        end
        if (c_hour) begin
            adv.day = c_day ? 5'(day_inc - len) : day_inc[4:0];
        end
        if (c_day) begin
            adv.month = c_mon ? 4'(mon_inc - utc_pkg::MONTH_PER_YEAR) : mon_inc[3:0];
        end
        if (c_mon) begin
            adv.year = (year_inc >= utc_pkg::YEAR_WRAP) ? 7'd0 : year_inc[6:0];
        end

        applied = 1'b0;
        if (action == utc_pkg::ACT_LOAD) begin
            nxt = load;
        end else if (pps_seen && (elapsed_ms < 10'(utc_pkg::MS_PER_SEC))) begin
            nxt     = adv;
            applied = 1'b1;
        end else begin
            nxt = cur;
        end
    end

endmodule

FILE: rtl/utc_date_time_advance.sv
// ---------------------------------------------------------------------------
// utc_date_time_advance
// UTC calendar clock: load a fix, advance by elapsed ms with full carry, or hold.
// ---------------------------------------------------------------------------
//  channel   prefix  handshake       payload
//  input     s_      s_valid/s_ready action, pps_seen, elapsed_ms, load_*
//  result    m_      m_valid/m_ready cur_*, advance_applied
//
//  One item per cycle sustained while the result channel is not stalled.
//  The whole carry chain is one combinational pass between the input
//  register and the result register, which also updates the time state.
//  Synchronous active-low reset clears the time to zero and empties both stages.
//  A stalled result holds; the input register still accepts one item behind it.
// ---------------------------------------------------------------------------
module utc_date_time_advance (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic       s_pps_seen,
    input  logic [9:0] s_elapsed_ms,
    input  logic [9:0] s_load_millisecond,
    input  logic [5:0] s_load_second,
    input  logic [5:0] s_load_minute,
    input  logic [4:0] s_load_hour,
    input  logic [4:0] s_load_day,
    input  logic [3:0] s_load_month,
    input  logic [6:0] s_load_year,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [9:0] m_cur_millisecond,
    output logic [5:0] m_cur_second,
    output logic [5:0] m_cur_minute,
    output logic [4:0] m_cur_hour,
    output logic [4:0] m_cur_day,
    output logic [3:0] m_cur_month,
    output logic [6:0] m_cur_year,
    output logic       m_advance_applied
);

    logic               in_valid_reg;
    logic               action_reg;
    logic               pps_reg;
    logic [9:0]         elapsed_reg;
    utc_pkg::cal_time_t load_reg;
    utc_pkg::cal_time_t state_reg;
    utc_pkg::cal_time_t state_next;
    logic               applied_next;
    logic               out_valid_reg;
    utc_pkg::cal_time_t out_reg;
    logic               applied_reg;
    logic               fire;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    utc_step u_step (
        .cur        (state_reg),
        .load       (load_reg),
        .action     (action_reg),
        .pps_seen   (pps_reg),
        .elapsed_ms (elapsed_reg),
        .nxt        (state_next),
        .applied    (applied_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg           <= s_action;
            pps_reg              <= s_pps_seen;
            elapsed_reg          <= s_elapsed_ms;
            load_reg.millisecond <= s_load_millisecond;
            load_reg.second      <= s_load_second;
            load_reg.minute      <= s_load_minute;
            load_reg.hour        <= s_load_hour;
            load_reg.day         <= s_load_day;
            load_reg.month       <= s_load_month;
            load_reg.year        <= s_load_year;
        end
        if (fire) begin
            out_reg     <= state_next;
            applied_reg <= applied_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_cur_millisecond = out_reg.millisecond;
    assign m_cur_second      = out_reg.second;
    assign m_cur_minute      = out_reg.minute;
    assign m_cur_hour        = out_reg.hour;
    assign m_cur_day         = out_reg.day;
    assign m_cur_month       = out_reg.month;
    assign m_cur_year        = out_reg.year;
    assign m_advance_applied = applied_reg;

endmodule

FILE: rtl/utc_checker.sv
// ---------------------------------------------------------------------------
// utc_checker
// Port-level checks for utc_date_time_advance, bound to the top level.
// ---------------------------------------------------------------------------
`include "utc_date_time_advance_assert.svh"

module utc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_action,
    input logic [9:0] s_load_millisecond,
    input logic [4:0] s_load_day,
    input logic [6:0] s_load_year,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_cur_millisecond,
    input logic [4:0] m_cur_day,
    input logic [6:0] m_cur_year,
    input logic       m_advance_applied
);

    `UTC_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_cur_millisecond) && $stable(m_cur_day) && $stable(m_advance_applied), "stalled item changed")

    `UTC_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid, "result valid after reset")

    `UTC_ASSERT(a_load_through, (s_valid && s_ready && !m_valid && s_action == utc_pkg::ACT_LOAD) ##1 m_ready |=> m_valid && !m_advance_applied && m_cur_millisecond == $past(s_load_millisecond, 2) && m_cur_day == $past(s_load_day, 2) && m_cur_year == $past(s_load_year, 2), "load item not delivered")

endmodule

bind utc_date_time_advance utc_checker u_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_action           (s_action),
    .s_load_millisecond (s_load_millisecond),
    .s_load_day         (s_load_day),
    .s_load_year        (s_load_year),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_cur_millisecond  (m_cur_millisecond),
    .m_cur_day          (m_cur_day),
    .m_cur_year         (m_cur_year),
    .m_advance_applied  (m_advance_applied)
);
